/* sv/tapp_pkg.sv */
// Shared types and constants of the three-axis PID position unit.
// Used by tapp_cfg, tapp_lane, tapp_merge and the top level; depends on nothing.
package tapp_pkg;

	localparam int NUM_AXES_DEF = 3;
	localparam int IO_AXES_MAX  = 3;

	localparam int POS_W    = 32;
	localparam int DT_W     = 21;
	localparam int GAIN_W   = 16;
	localparam int GAINS_W  = 48;
	localparam int LIM_W    = 31;
	localparam int DT_SHIFT = 20;
	localparam int OUT_SHIFT = 8;

	localparam int DIFF_W    = POS_W + 1;
	localparam int MAG_W     = POS_W;
	localparam int DIV_STEPS = MAG_W + DT_SHIFT;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int Q_W       = POS_W + 1;
	localparam int PROD_W    = POS_W + DT_W + 1;
	localparam int INC_W     = PROD_W - DT_SHIFT;
	localparam int ISUM_W    = INC_W + 1;
	localparam int TERM_W    = GAIN_W + POS_W;
	localparam int SUM_W     = TERM_W + 2;

	localparam int DATA_W      = 64;
	localparam int ADDR_W      = 5;
	localparam int REG_SEL_LSB = 3;
	localparam int REG_SEL_W   = ADDR_W - REG_SEL_LSB;

	localparam logic [REG_SEL_W-1:0] REG_PROP  = 2'd0;
	localparam logic [REG_SEL_W-1:0] REG_INTEG = 2'd1;
	localparam logic [REG_SEL_W-1:0] REG_DERIV = 2'd2;
	localparam logic [REG_SEL_W-1:0] REG_LIMIT = 2'd3;

	localparam logic [GAINS_W-1:0] PROP_RST  = 48'h0100_0100_0100;
	localparam logic [GAINS_W-1:0] INTEG_RST = '0;
	localparam logic [GAINS_W-1:0] DERIV_RST = '0;
	localparam logic [LIM_W-1:0]   LIMIT_RST = 31'd65536;

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	typedef struct packed {
		logic [GAINS_W-1:0] kp;
		logic [GAINS_W-1:0] ki;
		logic [GAINS_W-1:0] kd;
		logic [LIM_W-1:0]   lim;
	} tapp_cfg_t;

	typedef struct packed {
		logic            load;
		logic            prep;
		logic            step;
		logic            integ;
		logic            mul;
		logic            hold;
		logic [DT_W-1:0] dt;
	} tapp_ctl_t;

endpackage

/* sv/three_axis_pid_position_unit.sv */
// Three-axis PID position unit. One input word carries current and target
// positions, a time step and a hold flag; one result word carries the drives.
// Input and output channels use valid/stall; a word moves when valid is high
// and stall is low. The user must write configuration through the APB-style
// port only while the unit is idle; the unit itself does not enforce this.
// The axes run as parallel lanes. The error is captured at the accepting
// edge; then come the setup state, the restoring divider that forms the
// derivative (one quotient bit per cycle), the integral clamp, the gain
// products and the sum. One word is in work at a time and the input reopens
// in the cycle after the result is loaded.
// A finished result sits in the output register; the unit accepts the next
// word while it waits, and a stalled receiver only delays the hand-over of the
// following result. Reset clears the integrals, the last errors and the
// output valid, and loads the default gains and windup limit.
// Depends on tapp_pkg, tapp_cfg, tapp_lane and tapp_merge.
module three_axis_pid_position_unit #(
	parameter int NUM_AXES = tapp_pkg::NUM_AXES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [tapp_pkg::POS_W-1:0]  now_x,
	input  logic signed [tapp_pkg::POS_W-1:0]  now_y,
	input  logic signed [tapp_pkg::POS_W-1:0]  now_z,
	input  logic signed [tapp_pkg::POS_W-1:0]  goal_x,
	input  logic signed [tapp_pkg::POS_W-1:0]  goal_y,
	input  logic signed [tapp_pkg::POS_W-1:0]  goal_z,
	input  logic        [tapp_pkg::DT_W-1:0]   step_time,
	input  logic                              hold,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [tapp_pkg::POS_W-1:0]  drive_x,
	output logic signed [tapp_pkg::POS_W-1:0]  drive_y,
	output logic signed [tapp_pkg::POS_W-1:0]  drive_z,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tapp_pkg::ADDR_W-1:0]        paddr,
	input  logic [tapp_pkg::DATA_W-1:0]        pwdata,
	output logic [tapp_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import tapp_pkg::*;

	localparam int LANES = (NUM_AXES < IO_AXES_MAX) ? NUM_AXES : IO_AXES_MAX;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_INTEG = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;

	logic [2:0]                 state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [DT_W-1:0]            dt_q;
	logic                       hold_q;
	logic                       accept;
	logic                       res_load;
	logic                       out_free;
	tapp_cfg_t                  cfg;
	tapp_ctl_t                  ctl;
	logic [IO_AXES_MAX*POS_W-1:0] now_all;
	logic [IO_AXES_MAX*POS_W-1:0] goal_all;
	logic [LANES*POS_W-1:0]     res_all;

	tapp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;
	assign res_load = (state_q == ST_SUM) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_q <= ST_INTEG;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_INTEG: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_SUM;
				ST_SUM: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q   <= step_time;
			hold_q <= hold;
		end
	end

	assign ctl.load  = accept;
	assign ctl.prep  = state_q == ST_PREP;
	assign ctl.step  = state_q == ST_DIV;
	assign ctl.integ = state_q == ST_INTEG;
	assign ctl.mul   = state_q == ST_MUL;
	assign ctl.hold  = hold_q;
	assign ctl.dt    = dt_q;

	assign now_all  = {now_z, now_y, now_x};
	assign goal_all = {goal_z, goal_y, goal_x};

	for (genvar a = 0; a < LANES; a++) begin : g_lane
		tapp_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.now    (now_all[a*POS_W +: POS_W]),
			.goal   (goal_all[a*POS_W +: POS_W]),
			.kp     (cfg.kp[a*GAIN_W +: GAIN_W]),
			.ki     (cfg.ki[a*GAIN_W +: GAIN_W]),
			.kd     (cfg.kd[a*GAIN_W +: GAIN_W]),
			.lim    (cfg.lim),
			.res    (res_all[a*POS_W +: POS_W])
		);
	end

	tapp_merge #(
		.LANES (LANES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.hold      (hold_q),
		.res       (res_all),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.free      (out_free),
		.drive_x   (drive_x),
		.drive_y   (drive_y),
		.drive_z   (drive_z)
	);

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_PREP)
		else $error("accepted word did not start setup");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CNT_W'(DIV_STEPS))
		else $error("divider step count out of range");

	a_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && hold_q |=> drive_x == '0 && drive_y == '0 && drive_z == '0)
		else $error("held word produced nonzero drive");

endmodule

/* sv/tapp_cfg.sv */
// Configuration register file of the PID position unit, APB-style access.
// Depends on tapp_pkg.
module tapp_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tapp_pkg::ADDR_W-1:0] paddr,
	input  logic [tapp_pkg::DATA_W-1:0] pwdata,
	output logic [tapp_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output tapp_pkg::tapp_cfg_t         cfg
);
	import tapp_pkg::*;

	logic [GAINS_W-1:0]   kp_q;
	logic [GAINS_W-1:0]   ki_q;
	logic [GAINS_W-1:0]   kd_q;
	logic [LIM_W-1:0]     lim_q;
	logic [REG_SEL_W-1:0] sel;
	logic                 wr;

	assign pready = 1'b1;
	assign sel    = paddr[ADDR_W-1:REG_SEL_LSB];
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= PROP_RST;
			ki_q  <= INTEG_RST;
			kd_q  <= DERIV_RST;
			lim_q <= LIMIT_RST;
		end else if (wr) begin
			case (sel)
				REG_PROP:  kp_q  <= pwdata[GAINS_W-1:0];
				REG_INTEG: ki_q  <= pwdata[GAINS_W-1:0];
				REG_DERIV: kd_q  <= pwdata[GAINS_W-1:0];
				REG_LIMIT: lim_q <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_PROP:  prdata = {{(DATA_W-GAINS_W){1'b0}}, kp_q};
			REG_INTEG: prdata = {{(DATA_W-GAINS_W){1'b0}}, ki_q};
			REG_DERIV: prdata = {{(DATA_W-GAINS_W){1'b0}}, kd_q};
			REG_LIMIT: prdata = {{(DATA_W-LIM_W){1'b0}}, lim_q};
			default:   prdata = '0;
		endcase
	end

	assign cfg.kp  = kp_q;
	assign cfg.ki  = ki_q;
	assign cfg.kd  = kd_q;
	assign cfg.lim = lim_q;

endmodule

/* sv/tapp_lane.sv */
// One axis of the PID position unit: error, bit-serial derivative divider,
// clamped integral, gain products and saturated sum. Depends on tapp_pkg.
module tapp_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tapp_pkg::tapp_ctl_t               ctl,
	input  logic signed [tapp_pkg::POS_W-1:0]  now,
	input  logic signed [tapp_pkg::POS_W-1:0]  goal,
	input  logic signed [tapp_pkg::GAIN_W-1:0] kp,
	input  logic signed [tapp_pkg::GAIN_W-1:0] ki,
	input  logic signed [tapp_pkg::GAIN_W-1:0] kd,
	input  logic        [tapp_pkg::LIM_W-1:0]  lim,
	output logic signed [tapp_pkg::POS_W-1:0]  res
);
	import tapp_pkg::*;

	logic signed [DIFF_W-1:0] err_wide;
	logic signed [POS_W-1:0]  err_sat;
	logic signed [POS_W-1:0]  err_s1;
	logic signed [POS_W-1:0]  prior_q;
	logic signed [POS_W-1:0]  accum_q;

	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] diff_abs;
	logic [MAG_W-1:0]         mag_q;
	logic [DT_W-1:0]          rem_q;
	logic [Q_W-1:0]           quo_q;
	logic                     ovf_q;
	logic                     neg_q;
	logic signed [PROD_W-1:0] prod_s1;

	logic [DT_W:0]            trial;
	logic [DT_W:0]            trial_sub;
	logic                     fits;

	logic signed [POS_W-1:0]  deriv;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [INC_W-1:0]  inc;
	logic signed [ISUM_W-1:0] isum;
	logic signed [ISUM_W-1:0] lim_pos;
	logic signed [ISUM_W-1:0] lim_neg;
	logic signed [POS_W-1:0]  integ_val;
	logic signed [POS_W-1:0]  deriv_s2;
	logic signed [POS_W-1:0]  integ_s2;

	logic signed [TERM_W-1:0] tp_s3;
	logic signed [TERM_W-1:0] ti_s3;
	logic signed [TERM_W-1:0] td_s3;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_sh;
	logic [SUM_W-POS_W:0]     top_bits;

	assign err_wide = {goal[POS_W-1], goal} - {now[POS_W-1], now};
	assign err_sat  = (err_wide[DIFF_W-1] != err_wide[POS_W-1]) ?
		(err_wide[DIFF_W-1] ? POS_MIN : POS_MAX) : err_wide[POS_W-1:0];

	assign diff     = {err_s1[POS_W-1], err_s1} - {prior_q[POS_W-1], prior_q};
	assign diff_abs = diff[DIFF_W-1] ? -diff : diff;

	assign trial     = {rem_q, mag_q[MAG_W-1]};
	assign fits      = trial >= {1'b0, ctl.dt};
	assign trial_sub = trial - {1'b0, ctl.dt};

	always_comb begin
		if (ctl.dt == '0) begin
			deriv = '0;
		end else if (neg_q) begin
			if (ovf_q || quo_q > {2'b01, {(Q_W-2){1'b0}}})
				deriv = POS_MIN;
			else
				deriv = -$signed(quo_q[POS_W-1:0]);
		end else begin
			if (ovf_q || quo_q[Q_W-1] || quo_q[Q_W-2])
				deriv = POS_MAX;
			else
				deriv = $signed(quo_q[POS_W-1:0]);
		end
	end

	assign prod_sh = prod_s1 >>> DT_SHIFT;
	assign inc     = prod_sh[INC_W-1:0];
	assign isum    = {{(ISUM_W-POS_W){accum_q[POS_W-1]}}, accum_q} + {inc[INC_W-1], inc};
	assign lim_pos = {{(ISUM_W-LIM_W){1'b0}}, lim};
	assign lim_neg = -lim_pos;

	always_comb begin
		if (isum > lim_pos)
			integ_val = lim_pos[POS_W-1:0];
		else if (isum < lim_neg)
			integ_val = lim_neg[POS_W-1:0];
		else
			integ_val = isum[POS_W-1:0];
	end

	assign sum = {{(SUM_W-TERM_W){tp_s3[TERM_W-1]}}, tp_s3}
		+ {{(SUM_W-TERM_W){ti_s3[TERM_W-1]}}, ti_s3}
		+ {{(SUM_W-TERM_W){td_s3[TERM_W-1]}}, td_s3};
	assign sum_sh   = sum >>> OUT_SHIFT;
	assign top_bits = sum_sh[SUM_W-1:POS_W-1];
	assign res = ((&top_bits) || !(|top_bits)) ? sum_sh[POS_W-1:0] :
		(sum_sh[SUM_W-1] ? POS_MIN : POS_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q <= '0;
			accum_q <= '0;
		end else begin
			if (ctl.prep) begin
				if (ctl.hold)
					accum_q <= '0;
				else
					prior_q <= err_s1;
			end
			if (ctl.integ && !ctl.hold)
				accum_q <= integ_val;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			err_s1 <= err_sat;
		if (ctl.prep) begin
			mag_q   <= diff_abs[MAG_W-1:0];
			neg_q   <= diff[DIFF_W-1];
			rem_q   <= '0;
			quo_q   <= '0;
			ovf_q   <= 1'b0;
			prod_s1 <= err_s1 * $signed({1'b0, ctl.dt});
		end
		if (ctl.step) begin
			mag_q <= mag_q << 1;
			rem_q <= fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], fits};
			ovf_q <= ovf_q | quo_q[Q_W-1];
		end
		if (ctl.integ) begin
			deriv_s2 <= deriv;
			integ_s2 <= integ_val;
		end
		if (ctl.mul) begin
			tp_s3 <= kp * err_s1;
			ti_s3 <= ki * integ_s2;
			td_s3 <= kd * deriv_s2;
		end
	end

endmodule

/* sv/tapp_merge.sv */
// Output stage of the PID position unit: gathers the lane results into one
// result word and holds it for the receiver. Depends on tapp_pkg.
module tapp_merge #(
	parameter int LANES = tapp_pkg::IO_AXES_MAX
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              hold,
	input  logic [LANES*tapp_pkg::POS_W-1:0]   res,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic                              free,
	output logic signed [tapp_pkg::POS_W-1:0]  drive_x,
	output logic signed [tapp_pkg::POS_W-1:0]  drive_y,
	output logic signed [tapp_pkg::POS_W-1:0]  drive_z
);
	import tapp_pkg::*;

	logic                           valid_q;
	logic [IO_AXES_MAX*POS_W-1:0]   word_d;
	logic [IO_AXES_MAX*POS_W-1:0]   word_q;

	for (genvar a = 0; a < IO_AXES_MAX; a++) begin : g_axis
		if (a < LANES) begin : g_used
			assign word_d[a*POS_W +: POS_W] = hold ? '0 : res[a*POS_W +: POS_W];
		end else begin : g_unused
			assign word_d[a*POS_W +: POS_W] = '0;
		end
	end

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			word_q <= word_d;
	end

	assign out_valid = valid_q;
	assign drive_x   = word_q[0*POS_W +: POS_W];
	assign drive_y   = word_q[1*POS_W +: POS_W];
	assign drive_z   = word_q[2*POS_W +: POS_W];

endmodule

/* bench/pid_drive_checker.sv */
// Scoreboard for three_axis_pid_position_unit: mirrors the gain and limit
// registers from APB writes, predicts the drive word of every accepted input
// word and compares it with the result channel. Depends on tapp_pkg.
module pid_drive_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [tapp_pkg::POS_W-1:0] now_x,
	input  logic signed [tapp_pkg::POS_W-1:0] now_y,
	input  logic signed [tapp_pkg::POS_W-1:0] now_z,
	input  logic signed [tapp_pkg::POS_W-1:0] goal_x,
	input  logic signed [tapp_pkg::POS_W-1:0] goal_y,
	input  logic signed [tapp_pkg::POS_W-1:0] goal_z,
	input  logic        [tapp_pkg::DT_W-1:0]  step_time,
	input  logic                              hold,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [tapp_pkg::POS_W-1:0] drive_x,
	input  logic signed [tapp_pkg::POS_W-1:0] drive_y,
	input  logic signed [tapp_pkg::POS_W-1:0] drive_z,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic        [tapp_pkg::ADDR_W-1:0] paddr,
	input  logic        [tapp_pkg::DATA_W-1:0] pwdata,
	input  logic                              pready,
	output int                                mismatches,
	output int                                pending_words,
	output int                                drives_checked
);
	import tapp_pkg::*;

	typedef logic [2:0][POS_W-1:0] drive_set_t;

	tapp_cfg_t               regs_mirror;
	logic signed [POS_W-1:0] last_err [3];
	logic signed [POS_W-1:0] integ_acc [3];
	drive_set_t              expected_drives [$];
	int                      fail_tally = 0;
	int                      checked_tally = 0;
	string                   axis_name [3] = '{"drive_x", "drive_y", "drive_z"};

	function automatic longint clip32(input longint v);
		if (v > longint'(POS_MAX)) return longint'(POS_MAX);
		if (v < longint'(POS_MIN)) return longint'(POS_MIN);
		return v;
	endfunction

	function automatic longint gain_at(input logic [GAINS_W-1:0] packed_gains, input int axis);
		logic signed [GAIN_W-1:0] g;
		g = packed_gains[axis*GAIN_W +: GAIN_W];
		return longint'(g);
	endfunction

	function automatic drive_set_t pid_step(input drive_set_t cur, input drive_set_t tgt,
			input logic [DT_W-1:0] dt, input logic hold_f);
		drive_set_t drives;
		longint     err, rate, integ, total, span, lim;
		int         a;
		drives = '0;
		span = longint'(dt);
		lim = longint'(regs_mirror.lim);
		if (hold_f) begin
			for (a = 0; a < 3; a++)
				integ_acc[a] = '0;
			return drives;
		end
		for (a = 0; a < 3; a++) begin
			err = clip32(longint'(signed'(tgt[a])) - longint'(signed'(cur[a])));
			rate = 0;
			if (span > 0)
				rate = clip32(((err - longint'(last_err[a])) * (longint'(1) << DT_SHIFT)) / span);
			last_err[a] = err[POS_W-1:0];
			integ = longint'(integ_acc[a]) + ((err * span) >>> DT_SHIFT);
			if (integ > lim) integ = lim;
			if (integ < -lim) integ = -lim;
			integ_acc[a] = integ[POS_W-1:0];
			total = gain_at(regs_mirror.kp, a) * err + gain_at(regs_mirror.ki, a) * integ
				+ gain_at(regs_mirror.kd, a) * rate;
			drives[a] = POS_W'(clip32(total >>> OUT_SHIFT));
		end
		return drives;
	endfunction

	task automatic flag(input string what);
		fail_tally++;
		if (fail_tally <= 10)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin
		drive_set_t got, want;
		int         a;
		if (!arst_n) begin
			regs_mirror.kp = PROP_RST;
			regs_mirror.ki = INTEG_RST;
			regs_mirror.kd = DERIV_RST;
			regs_mirror.lim = LIMIT_RST;
			for (a = 0; a < 3; a++) begin
				last_err[a] = '0;
				integ_acc[a] = '0;
			end
			expected_drives.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:REG_SEL_LSB])
					REG_PROP:  regs_mirror.kp = pwdata[GAINS_W-1:0];
					REG_INTEG: regs_mirror.ki = pwdata[GAINS_W-1:0];
					REG_DERIV: regs_mirror.kd = pwdata[GAINS_W-1:0];
					REG_LIMIT: regs_mirror.lim = pwdata[LIM_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = {drive_z, drive_y, drive_x};
				checked_tally++;
				if (expected_drives.size() == 0) begin
					flag($sformatf("drive word %0d/%0d/%0d arrived with none pending",
						drive_x, drive_y, drive_z));
				end else begin
					want = expected_drives.pop_front();
					for (a = 0; a < 3; a++)
						if (got[a] !== want[a])
							flag($sformatf("%s: expected %0d, got %0d", axis_name[a],
								$signed(want[a]), $signed(got[a])));
				end
			end
			if (in_valid && !in_stall)
				expected_drives.push_back(pid_step({now_z, now_y, now_x},
					{goal_z, goal_y, goal_x}, step_time, hold));
		end
		mismatches <= fail_tally;
		pending_words <= expected_drives.size();
		drives_checked <= checked_tally;
	end

endmodule

/* bench/tb_three_axis_pid_position_unit.sv */
// Testbench top for three_axis_pid_position_unit: drives directed and random
// position words and APB register settings, stalls the result side at random
// and reports the verdict. Depends on tapp_pkg, the unit and pid_drive_checker.
module tb_three_axis_pid_position_unit;
	import tapp_pkg::*;

	localparam int PHASES       = 8;
	localparam int PHASE_WORDS  = 173;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 64;

	typedef logic [2:0][POS_W-1:0] axis_vec_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [POS_W-1:0] now_x = '0;
	logic signed [POS_W-1:0] now_y = '0;
	logic signed [POS_W-1:0] now_z = '0;
	logic signed [POS_W-1:0] goal_x = '0;
	logic signed [POS_W-1:0] goal_y = '0;
	logic signed [POS_W-1:0] goal_z = '0;
	logic [DT_W-1:0]         step_time = '0;
	logic                    hold = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [POS_W-1:0] drive_x, drive_y, drive_z;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [ADDR_W-1:0]       paddr = '0;
	logic [DATA_W-1:0]       pwdata = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;

	int     mismatches, pending_words, drives_checked;
	int     words_sent = 0;
	int     holds_sent = 0;
	int     zero_steps_sent = 0;
	int     settings_used = 0;
	int     rx_wait = 0;
	int     idle_cycles = 0;
	bit     tx_burst = 1'b0;
	bit     rx_burst = 1'b0;
	longint track_now [3] = '{0, 0, 0};
	longint track_goal [3] = '{0, 0, 0};

	three_axis_pid_position_unit DUT (.*);

	pid_drive_checker watch (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		int n;
		if (out_valid && !out_stall) begin
			n = rx_burst ? 0 : $urandom_range(0, 15);
			rx_wait <= n;
			out_stall <= (n != 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			out_stall <= (rx_wait > 1);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles, %0d drive words outstanding",
				IDLE_LIMIT, pending_words);
			$display("three_axis_pid_position_unit test failed");
			$finish;
		end
	end

	task automatic send_word(input axis_vec_t cur, input axis_vec_t tgt,
			input logic [DT_W-1:0] span, input logic hold_f);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_x <= cur[0];
		now_y <= cur[1];
		now_z <= cur[2];
		goal_x <= tgt[0];
		goal_y <= tgt[1];
		goal_z <= tgt[2];
		step_time <= span;
		hold <= hold_f;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (hold_f) holds_sent++;
		else if (span == 0) zero_steps_sent++;
	endtask

	task automatic drain_results(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_words != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_SEL_W-1:0] sel, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, {REG_SEL_LSB{1'b0}}};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_regs(input logic [GAINS_W-1:0] kp, input logic [GAINS_W-1:0] ki,
			input logic [GAINS_W-1:0] kd, input logic [DATA_W-1:0] lim);
		drain_results(2);
		write_reg(REG_PROP, DATA_W'(kp));
		write_reg(REG_INTEG, DATA_W'(ki));
		write_reg(REG_DERIV, DATA_W'(kd));
		write_reg(REG_LIMIT, lim);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic [GAINS_W-1:0] pick_gains();
		logic [GAINS_W-1:0] g;
		int                 a;
		g[31:0] = $urandom();
		g[47:32] = 16'($urandom());
		if ($urandom_range(0, 1) == 0)
			for (a = 0; a < 3; a++)
				g[a*GAIN_W +: GAIN_W] = GAIN_W'($urandom_range(0, 2047) - 1024);
		return g;
	endfunction

	// Move each axis part way toward its goal; now and then pick new goals.
	task automatic next_track(output axis_vec_t cur, output axis_vec_t tgt,
			output logic [DT_W-1:0] span, output logic hold_f);
		longint diff;
		int     a, kind, jit, sh;
		bit     settled;
		kind = $urandom_range(0, 99);
		settled = 1'b1;
		if ($urandom_range(0, 39) == 0)
			for (a = 0; a < 3; a++)
				track_goal[a] = longint'($signed($urandom())) >>> $urandom_range(0, 20);
		for (a = 0; a < 3; a++) begin
			diff = track_goal[a] - track_now[a];
			sh = $urandom_range(1, 4);
			jit = int'($urandom_range(0, 512)) - 256;
			track_now[a] = track_now[a] + (diff >>> sh) + jit;
			if (track_now[a] > longint'(POS_MAX)) track_now[a] = longint'(POS_MAX);
			if (track_now[a] < longint'(POS_MIN)) track_now[a] = longint'(POS_MIN);
			diff = track_goal[a] - track_now[a];
			if (diff > 1024 || diff < -1024) settled = 1'b0;
			cur[a] = track_now[a][POS_W-1:0];
			tgt[a] = track_goal[a][POS_W-1:0];
		end
		hold_f = (kind < 6) || (settled && kind < 40);
		if (kind < 10)
			span = '0;
		else if (kind < 14)
			span = DT_W'($urandom_range(1 << DT_SHIFT, (1 << DT_W) - 1));
		else if (kind < 18)
			span = DT_W'($urandom_range(1, 8));
		else
			span = DT_W'($urandom_range(200, 4000));
	endtask

	initial begin
		axis_vec_t          nw, gl;
		logic [DT_W-1:0]    span;
		logic               hold_f;
		logic [DATA_W-1:0]  lim;
		int                 phase, n, a;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word('0, '0, '0, 1'b0);
		send_word({3{POS_MIN}}, {3{POS_MAX}}, DT_W'(1), 1'b0);
		send_word({3{POS_MAX}}, {3{POS_MIN}}, {DT_W{1'b1}}, 1'b0);
		send_word({32'sd65536, -32'sd7, 32'sd5}, '0, '0, 1'b0);
		send_word({$urandom(), $urandom(), $urandom()}, {$urandom(), $urandom(), $urandom()},
			DT_W'(1000), 1'b1);

		set_regs({3{16'h7FFF}}, {3{16'h8000}}, {16'h0001, 16'h8000, 16'h7FFF}, 64'h7FFF_FFFF);
		send_word({3{POS_MIN}}, {3{POS_MAX}}, DT_W'(1), 1'b0);
		send_word({3{POS_MAX}}, {3{POS_MIN}}, DT_W'(1), 1'b0);
		send_word({32'sd0, -32'sd1000, 32'sd1000}, '0, DT_W'(1 << DT_SHIFT), 1'b0);
		send_word({32'sd0, -32'sd1000, 32'sd1000}, '0, {DT_W{1'b1}}, 1'b0);
		send_word('0, {-32'sd3, -32'sd1, -32'sd3}, DT_W'(3), 1'b0);
		send_word({3{32'sd12345}}, '0, DT_W'(77), 1'b1);
		send_word({3{32'sd12345}}, '0, '0, 1'b0);

		set_regs({16'h0080, 16'hFF00, 16'h0100}, {16'h0001, 16'hFFC0, 16'h0040},
			{16'h0100, 16'hFFF0, 16'h0010}, {32'hDEAD_BEEF, 32'h0000_0000});
		send_word({$urandom(), $urandom(), $urandom()}, {$urandom(), $urandom(), $urandom()},
			DT_W'(500), 1'b0);
		send_word('0, {3{32'sd65536}}, DT_W'(1 << DT_SHIFT), 1'b0);
		send_word('0, {3{-32'sd65536}}, DT_W'(1 << DT_SHIFT), 1'b0);

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_regs({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 64'h7FFF_FFFF);
				1: set_regs({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, '0);
				default: begin
					if ($urandom_range(0, 1) == 0)
						lim = {$urandom(), $urandom()};
					else
						lim = DATA_W'($urandom_range(0, 1 << 20));
					set_regs(pick_gains(), pick_gains(), pick_gains(), lim);
				end
			endcase
			tx_burst = (phase == 2) || ($urandom_range(0, 3) == 0);
			rx_burst = (phase == 2) || ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_WORDS; n++) begin
				if ($urandom_range(0, 99) < 12) begin
					for (a = 0; a < 3; a++) begin
						nw[a] = $urandom();
						gl[a] = $urandom();
					end
					span = DT_W'($urandom_range(0, (1 << DT_W) - 1));
					hold_f = ($urandom_range(0, 7) == 0);
				end else begin
					next_track(nw, gl, span, hold_f);
				end
				send_word(nw, gl, span, hold_f);
			end
		end

		drain_results(DRAIN_CYCLES);
		$display("Sent %0d position words (%0d held, %0d with zero step time) over %0d register settings;",
			words_sent, holds_sent, zero_steps_sent, settings_used);
		$display("compared %0d drive words, %0d mismatches.", drives_checked, mismatches);
		if (mismatches == 0 && pending_words == 0)
			$display("three_axis_pid_position_unit test passed");
		else
			$display("three_axis_pid_position_unit test failed");
		$finish;
	end

endmodule

/* three_axis_pid_position_unit.f */
sv/tapp_pkg.sv
sv/tapp_cfg.sv
sv/tapp_lane.sv
sv/tapp_merge.sv
sv/three_axis_pid_position_unit.sv
bench/pid_drive_checker.sv
bench/tb_three_axis_pid_position_unit.sv
